/* sv/assert_macros.svh */
// shared assertion macros for the resonator bank checkers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is high
`define MRB_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds across reset
`define MRB_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/mrb_pkg.sv */
package mrb_pkg;

  localparam int CHANNELS   = 2;
  localparam int SAMPLE_W   = 24;
  localparam int COEF_W     = 32;
  localparam int DELAY_W    = 40;
  localparam int SPLIT_W    = 20;
  localparam int PROD_W     = COEF_W + DELAY_W;
  localparam int FRAC_DROP  = 28;
  localparam int Q_W        = PROD_W - FRAC_DROP;
  localparam int X_SHIFT    = 7;
  localparam int W0RAW_W    = Q_W + 2;
  localparam int HI_PROD_W  = COEF_W + DELAY_W - SPLIT_W;
  localparam int LO_PROD_W  = COEF_W + SPLIT_W + 1;
  localparam int RES_SEL_W  = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int IN_DATA_W  = 64;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 48;

  localparam logic [SAMPLE_W-1:0] SAMPLE_POS_LIMIT = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic [SAMPLE_W-1:0] SAMPLE_NEG_LIMIT = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam logic [DELAY_W-1:0]  DELAY_POS_LIMIT  = {1'b0, {(DELAY_W-1){1'b1}}};
  localparam logic [DELAY_W-1:0]  DELAY_NEG_LIMIT  = {1'b1, {(DELAY_W-1){1'b0}}};

  typedef enum logic {
    REQ_SAMPLE,
    REQ_COEF
  } mrb_req_t;

  typedef enum logic [1:0] {
    KIND_A1,
    KIND_A2,
    KIND_B0,
    KIND_B1
  } mrb_coef_kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RUN_ENABLE,
    CFG_BYPASS,
    CFG_MUTE
  } mrb_cfg_idx_t;

  // one resonator slot entering the pipeline
  typedef struct packed {
    logic valid;
    logic chan;
    logic first;
    logic last;
  } mrb_issue_t;

  typedef struct packed {
    logic               valid;
    logic [DELAY_W-1:0] w1;
    logic [DELAY_W-1:0] w2;
  } mrb_wb_t;

  typedef struct packed {
    logic                valid;
    logic [SAMPLE_W-1:0] left;
    logic [SAMPLE_W-1:0] right;
    logic                clip;
  } mrb_result_t;

  // rebuild coef*delay from its two partial products, floor to 30 fraction bits
  function automatic logic signed [Q_W-1:0] join_prod(
    input logic signed [HI_PROD_W-1:0] hi,
    input logic signed [LO_PROD_W-1:0] lo
  );
    logic signed [PROD_W-1:0] p;
    p = (PROD_W'(hi) <<< SPLIT_W) + PROD_W'(lo);
    return p[PROD_W-1:FRAC_DROP];
  endfunction

  // saturate w0 to the delay width, msb of the result is the overflow flag
  function automatic logic [DELAY_W:0] sat_delay(input logic signed [W0RAW_W-1:0] v);
    logic ovf;
    ovf = !((&v[W0RAW_W-1:DELAY_W-1]) || !(|v[W0RAW_W-1:DELAY_W-1]));
    if (ovf) begin
      return {1'b1, v[W0RAW_W-1] ? DELAY_NEG_LIMIT : DELAY_POS_LIMIT};
    end
    return {1'b0, v[DELAY_W-1:0]};
  endfunction

endpackage

/* sv/modal_resonator_bank.sv */
// Modal resonator bank: one mono Q1.23 sample drives 2*MODES_PER_CHANNEL
// two-pole/one-zero resonators whose delays live in one RAM and whose four
// coefficients live in four RAMs; a single multiply pipeline walks the bank one
// resonator per cycle, and the next request is taken only after a filtered sample's
// result has left the pipeline. Bypassed or muted samples skip the pipeline, and
// coefficient writes and samples while disabled leave the block idle. A result
// still stalled in the output register holds the next one back until it is taken.
// After reset the block clears the delay RAM with s_axis_tready low; config
// writes are taken throughout. Coefficients must all be written before
// the first filtered sample. The finished result sits in an output register, so
// the next request is taken while it waits.
module modal_resonator_bank #(
  parameter int MODES_PER_CHANNEL = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // sample_in[23:0], coef_resonator[30:24], coef_value[62:31], zero[63]
  input  logic [mrb_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // req_type[0], coef_kind[2:1]
  input  logic [mrb_pkg::IN_USER_W-1:0]     s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // left_out[23:0], right_out[47:24]
  output logic [mrb_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // clipped[0]
  output logic                              m_axis_tuser,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mrb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic                              cfg_data
);

  localparam int RES_COUNT = mrb_pkg::CHANNELS * MODES_PER_CHANNEL;
  localparam int RA_W      = $clog2(RES_COUNT);
  localparam int MD_W      = (MODES_PER_CHANNEL > 1) ? $clog2(MODES_PER_CHANNEL) : 1;
  localparam int SW        = mrb_pkg::SAMPLE_W;
  localparam int DW        = mrb_pkg::DELAY_W;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  state_t state;

  logic run_enable, bypass_on, mute_on;

  logic [RA_W-1:0] idx, wb_idx;
  logic [MD_W-1:0] mode;
  logic            chan;
  logic            last_slot;
  logic signed [SW-1:0] sample_reg;

  logic [SW-1:0] pend_left, pend_right;
  logic          pend_clip;
  logic          m_valid;
  logic [SW-1:0] m_left, m_right;
  logic          m_clip;

  logic                          in_req;
  logic                          req_type;
  logic signed [SW-1:0]          sample_in;
  logic [mrb_pkg::RES_SEL_W-1:0] coef_resonator;
  logic [1:0]                    coef_kind;
  logic [mrb_pkg::COEF_W-1:0]    coef_value;
  logic                          coef_in_range;

  logic [mrb_pkg::COEF_W-1:0] coef_rd [4];
  logic [2*DW-1:0]            delay_rd;
  logic                       dl_we;
  logic [RA_W-1:0]            dl_waddr;
  logic [2*DW-1:0]            dl_wdata;

  mrb_pkg::mrb_issue_t  issue;
  mrb_pkg::mrb_wb_t     wb;
  mrb_pkg::mrb_result_t res;

  assign req_type       = s_axis_tuser[0];
  assign coef_kind      = s_axis_tuser[2:1];
  assign sample_in      = s_axis_tdata[SW-1:0];
  assign coef_resonator = s_axis_tdata[30:24];
  assign coef_value     = s_axis_tdata[62:31];

  assign s_axis_tready  = (state == ST_IDLE);
  assign in_req         = s_axis_tvalid && s_axis_tready;
  assign coef_in_range  = 32'(coef_resonator) < RES_COUNT;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      run_enable <= 1'b0;
      bypass_on  <= 1'b0;
      mute_on    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mrb_pkg::CFG_RUN_ENABLE: run_enable <= cfg_data;
        mrb_pkg::CFG_BYPASS:     bypass_on  <= cfg_data;
        mrb_pkg::CFG_MUTE:       mute_on    <= cfg_data;
        default:                 ;
      endcase
    end
  end

  // coefficient store, one RAM per coefficient kind
  for (genvar k = 0; k < 4; k++) begin : g_coef
    mrb_ram #(
      .WIDTH(mrb_pkg::COEF_W),
      .DEPTH(RES_COUNT)
    ) u_coef_ram (
      .clk  (clk),
      .we   (in_req && (req_type == mrb_pkg::REQ_COEF) && coef_in_range
             && (coef_kind == 2'(k))),
      .waddr(RA_W'(coef_resonator)),
      .wdata(coef_value),
      .raddr(idx),
      .rdata(coef_rd[k])
    );
  end

  // delay store: w1 in the upper half, w2 in the lower half
  assign dl_we    = (state == ST_CLEAR) || wb.valid;
  assign dl_waddr = (state == ST_CLEAR) ? idx : wb_idx;
  assign dl_wdata = (state == ST_CLEAR) ? '0 : {wb.w1, wb.w2};

  mrb_ram #(
    .WIDTH(2 * DW),
    .DEPTH(RES_COUNT)
  ) u_delay_ram (
    .clk  (clk),
    .we   (dl_we),
    .waddr(dl_waddr),
    .wdata(dl_wdata),
    .raddr(idx),
    .rdata(delay_rd)
  );

  assign last_slot   = chan && (mode == MD_W'(MODES_PER_CHANNEL - 1));
  assign issue.valid = (state == ST_RUN);
  assign issue.chan  = chan;
  assign issue.first = (mode == '0);
  assign issue.last  = last_slot;

  mrb_mac_pipe #(
    .MODES_PER_CHANNEL(MODES_PER_CHANNEL)
  ) u_pipe (
    .clk  (clk),
    .rst  (rst),
    .issue(issue),
    .x    (sample_reg),
    .a1   (coef_rd[mrb_pkg::KIND_A1]),
    .a2   (coef_rd[mrb_pkg::KIND_A2]),
    .b0   (coef_rd[mrb_pkg::KIND_B0]),
    .b1   (coef_rd[mrb_pkg::KIND_B1]),
    .w1   (delay_rd[2*DW-1:DW]),
    .w2   (delay_rd[DW-1:0]),
    .wb   (wb),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      idx     <= '0;
      wb_idx  <= '0;
      mode    <= '0;
      chan    <= 1'b0;
      m_valid <= 1'b0;
    end else begin
      if (m_valid && m_axis_tready && (state != ST_EMIT)) begin
        m_valid <= 1'b0;
      end
      if (wb.valid) begin
        wb_idx <= wb_idx + 1'b1;
      end
      case (state)
        ST_CLEAR: begin
          if (idx == RA_W'(RES_COUNT - 1)) begin
            idx   <= '0;
            state <= ST_IDLE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        ST_IDLE: begin
          if (in_req && (req_type == mrb_pkg::REQ_SAMPLE) && run_enable) begin
            if (bypass_on) begin
              pend_left  <= sample_in;
              pend_right <= sample_in;
              pend_clip  <= 1'b0;
              state      <= ST_EMIT;
            end else if (mute_on) begin
              pend_left  <= '0;
              pend_right <= '0;
              pend_clip  <= 1'b0;
              state      <= ST_EMIT;
            end else begin
              sample_reg <= sample_in;
              idx        <= '0;
              wb_idx     <= '0;
              mode       <= '0;
              chan       <= 1'b0;
              state      <= ST_RUN;
            end
          end
        end
        ST_RUN: begin
          if (last_slot) begin
            idx   <= '0;
            mode  <= '0;
            chan  <= 1'b0;
            state <= ST_DRAIN;
          end else begin
            idx <= idx + 1'b1;
            if (mode == MD_W'(MODES_PER_CHANNEL - 1)) begin
              mode <= '0;
              chan <= 1'b1;
            end else begin
              mode <= mode + 1'b1;
            end
          end
        end
        ST_DRAIN: begin
          if (res.valid) begin
            pend_left  <= res.left;
            pend_right <= res.right;
            pend_clip  <= res.clip;
            state      <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (!m_valid || m_axis_tready) begin
            m_valid <= 1'b1;
            m_left  <= pend_left;
            m_right <= pend_right;
            m_clip  <= pend_clip;
            state   <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = m_valid;
  assign m_axis_tdata  = {m_right, m_left};
  assign m_axis_tuser  = m_clip;

endmodule

/* sv/mrb_ram.sv */
module mrb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/mrb_mac_pipe.sv */
module mrb_mac_pipe #(
  parameter int MODES_PER_CHANNEL = 64
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  mrb_pkg::mrb_issue_t                   issue,
  input  logic signed [mrb_pkg::SAMPLE_W-1:0]   x,
  input  logic signed [mrb_pkg::COEF_W-1:0]     a1,
  input  logic signed [mrb_pkg::COEF_W-1:0]     a2,
  input  logic signed [mrb_pkg::COEF_W-1:0]     b0,
  input  logic signed [mrb_pkg::COEF_W-1:0]     b1,
  input  logic signed [mrb_pkg::DELAY_W-1:0]    w1,
  input  logic signed [mrb_pkg::DELAY_W-1:0]    w2,
  output mrb_pkg::mrb_wb_t                      wb,
  output mrb_pkg::mrb_result_t                  res
);

  localparam int ACC_W = mrb_pkg::Q_W + 1 + $clog2(MODES_PER_CHANNEL) + 1;
  localparam int Y_W   = ACC_W - mrb_pkg::X_SHIFT;
  localparam int SW    = mrb_pkg::SAMPLE_W;
  localparam int DW    = mrb_pkg::DELAY_W;
  localparam int HW    = mrb_pkg::HI_PROD_W;
  localparam int LW    = mrb_pkg::LO_PROD_W;
  localparam int QW    = mrb_pkg::Q_W;
  localparam int SPW   = mrb_pkg::SPLIT_W;

  mrb_pkg::mrb_issue_t m0, m1, m2, m3, m4, m5, m6;
  logic fin;

  logic signed [HW-1:0] p1h, p2h, p4h, p3h;
  logic signed [LW-1:0] p1l, p2l, p4l, p3l;
  logic signed [DW-1:0] w1_1, w1_2, w1_3, w1_4;
  logic signed [mrb_pkg::COEF_W-1:0] b0_1, b0_2, b0_3, b0_4;
  logic signed [QW-1:0] q1, q2, q4_2, q4_3, q4_4, q4_5, q4_6, q3_6;
  logic signed [mrb_pkg::W0RAW_W-1:0] w0raw;
  logic signed [DW-1:0] w0_4;
  logic sat4, sat5, sat6;
  logic [DW:0] sat_res;
  logic signed [ACC_W-1:0] acc_l, acc_r, acc_add;
  logic clip_acc;

  logic signed [Y_W-1:0] yl, yr;
  logic ovf_l, ovf_r;
  logic [SW-1:0] sat_l, sat_r;

  // slot tags travel alongside the data
  always_ff @(posedge clk) begin
    if (rst) begin
      m0  <= '0;
      m1  <= '0;
      m2  <= '0;
      m3  <= '0;
      m4  <= '0;
      m5  <= '0;
      m6  <= '0;
      fin <= 1'b0;
    end else begin
      m0  <= issue;
      m1  <= m0;
      m2  <= m1;
      m3  <= m2;
      m4  <= m3;
      m5  <= m4;
      m6  <= m5;
      fin <= m6.valid && m6.last;
    end
  end

  assign sat_res = mrb_pkg::sat_delay(w0raw);

  always_ff @(posedge clk) begin
    // partial products of the feedback and b1 terms
    p1h  <= a1 * $signed(w1[DW-1:SPW]);
    p1l  <= a1 * $signed({1'b0, w1[SPW-1:0]});
    p2h  <= a2 * $signed(w2[DW-1:SPW]);
    p2l  <= a2 * $signed({1'b0, w2[SPW-1:0]});
    p4h  <= b1 * $signed(w1[DW-1:SPW]);
    p4l  <= b1 * $signed({1'b0, w1[SPW-1:0]});
    w1_1 <= w1;
    b0_1 <= b0;

    q1   <= mrb_pkg::join_prod(p1h, p1l);
    q2   <= mrb_pkg::join_prod(p2h, p2l);
    q4_2 <= mrb_pkg::join_prod(p4h, p4l);
    w1_2 <= w1_1;
    b0_2 <= b0_1;

    w0raw <= (mrb_pkg::W0RAW_W'(x) <<< mrb_pkg::X_SHIFT)
             - mrb_pkg::W0RAW_W'(q1) - mrb_pkg::W0RAW_W'(q2);
    q4_3  <= q4_2;
    w1_3  <= w1_2;
    b0_3  <= b0_2;

    sat4 <= sat_res[DW];
    w0_4 <= sat_res[DW-1:0];
    q4_4 <= q4_3;
    w1_4 <= w1_3;
    b0_4 <= b0_3;

    p3h  <= b0_4 * $signed(w0_4[DW-1:SPW]);
    p3l  <= b0_4 * $signed({1'b0, w0_4[SPW-1:0]});
    q4_5 <= q4_4;
    sat5 <= sat4;

    q3_6 <= mrb_pkg::join_prod(p3h, p3l);
    q4_6 <= q4_5;
    sat6 <= sat5;
  end

  // new delays leave the pipeline in resonator order
  assign wb.valid = m4.valid;
  assign wb.w1    = w0_4;
  assign wb.w2    = w1_4;

  assign acc_add = ACC_W'(q3_6) + ACC_W'(q4_6);

  always_ff @(posedge clk) begin
    if (m6.valid) begin
      if (m6.chan) begin
        acc_r <= m6.first ? acc_add : acc_r + acc_add;
      end else begin
        acc_l <= m6.first ? acc_add : acc_l + acc_add;
      end
      clip_acc <= (m6.first && !m6.chan) ? sat6 : (clip_acc | sat6);
    end
  end

  // channel sums down to 23 fraction bits, then clamp to the sample range
  assign yl    = acc_l[ACC_W-1:mrb_pkg::X_SHIFT];
  assign yr    = acc_r[ACC_W-1:mrb_pkg::X_SHIFT];
  assign ovf_l = !((&yl[Y_W-1:SW-1]) || !(|yl[Y_W-1:SW-1]));
  assign ovf_r = !((&yr[Y_W-1:SW-1]) || !(|yr[Y_W-1:SW-1]));
  assign sat_l = ovf_l ? (yl[Y_W-1] ? mrb_pkg::SAMPLE_NEG_LIMIT : mrb_pkg::SAMPLE_POS_LIMIT)
                       : yl[SW-1:0];
  assign sat_r = ovf_r ? (yr[Y_W-1] ? mrb_pkg::SAMPLE_NEG_LIMIT : mrb_pkg::SAMPLE_POS_LIMIT)
                       : yr[SW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else begin
      res.valid <= fin;
    end
    res.left  <= sat_l;
    res.right <= sat_r;
    res.clip  <= clip_acc | ovf_l | ovf_r;
  end

endmodule

/* sv/mrb_checker.sv */
`include "assert_macros.svh"

module mrb_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic [mrb_pkg::IN_USER_W-1:0]  s_axis_tuser,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [mrb_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic                           m_axis_tuser
);

  // a waiting result stays put until taken
  `MRB_ASSERT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

  // reset empties the output and starts the delay clear with requests held off
  `MRB_ASSERT_ALWAYS(a_reset_state, clk, rst |=> !m_axis_tvalid && !s_axis_tready, "bad state after reset")

  // a coefficient write never blocks the next request
  `MRB_ASSERT(a_coef_no_stall, clk, rst, s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == mrb_pkg::REQ_COEF) |=> s_axis_tready, "stalled after coefficient write")

  // a new result only ever rises out of a busy state, never out of idle
  `MRB_ASSERT(a_result_from_work, clk, rst, $rose(m_axis_tvalid) |-> !$past(s_axis_tready), "result appeared while idle")

endmodule

bind modal_resonator_bank mrb_checker u_mrb_checker (
  .clk          (clk),
  .rst          (rst),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tuser (s_axis_tuser),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);
